// ----- rtl/wbcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Work/break countdown controller package
// Shared types and codes for the controller state, events and results.
// ----------------------------------------------------------------------------
package wbcc_pkg;

  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int VolW   = 3;
  localparam int GainW  = 8;
  localparam int BeepW  = 2;
  localparam int KeyW   = 4;
  localparam int StepW  = 4;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;

  localparam logic [MinW-1:0]     LIMIT_RESET = 6'd60;
  localparam logic [StepW-1:0]    STEP_RESET  = 4'd5;
  localparam logic [SecW-1:0]     SEC_RELOAD  = 6'd59;
  localparam logic [VolW-1:0]     VOL_RESET   = 3'd1;

  localparam logic [CfgIdxW-1:0]  CFG_SETTING_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0]  CFG_COARSE_STEP   = 1'd1;

  localparam logic [KeyW-1:0] KEY_ABORT    = 4'd0;
  localparam logic [KeyW-1:0] KEY_UP_CRS   = 4'd1;
  localparam logic [KeyW-1:0] KEY_DN_CRS   = 4'd2;
  localparam logic [KeyW-1:0] KEY_UP_FINE  = 4'd3;
  localparam logic [KeyW-1:0] KEY_DN_FINE  = 4'd4;
  localparam logic [KeyW-1:0] KEY_CONFIRM  = 4'd5;
  localparam logic [KeyW-1:0] KEY_POMODORO = 4'd6;
  localparam logic [KeyW-1:0] KEY_TIMER    = 4'd7;
  localparam logic [KeyW-1:0] KEY_CONTINUE = 4'd8;

  localparam logic [BeepW-1:0] BEEP_NONE = 2'd0;
  localparam logic [BeepW-1:0] BEEP_FOUR = 2'd1;
  localparam logic [BeepW-1:0] BEEP_TWO  = 2'd2;
  localparam logic [BeepW-1:0] BEEP_ONE  = 2'd3;

  typedef enum logic [3:0] {
    MODE_SELECT       = 4'd0,
    MODE_SET_WORK     = 4'd1,
    MODE_SET_TIMER    = 4'd2,
    MODE_TIMER_RUN    = 4'd3,
    MODE_WORK_RUN     = 4'd4,
    MODE_SET_BREAK    = 4'd5,
    MODE_BREAK_RUN    = 4'd6,
    MODE_SESSION_DONE = 4'd7,
    MODE_TIMER_DONE   = 4'd8
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [MinW-1:0]  timer_min;
    logic [MinW-1:0]  work_min;
    logic [MinW-1:0]  break_min;
    logic [MinW-1:0]  saved_work;
    logic [MinW-1:0]  saved_break;
    logic [SecW-1:0]  seconds;
    logic [VolW-1:0]  volume;
  } state_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [VolW-1:0]  volume;
    logic [GainW-1:0] gain;
    logic [BeepW-1:0] beep;
  } result_t;

endpackage

// ----- rtl/wbcc_step.sv -----
// ----------------------------------------------------------------------------
// Controller next-state logic
// Computes the next controller state and the result for one event.
// ----------------------------------------------------------------------------
module wbcc_step (
  input  wbcc_pkg::state_t                 st,
  input  logic                             is_key,
  input  logic [wbcc_pkg::KeyW-1:0]        key,
  input  logic [wbcc_pkg::MinW-1:0]        limit,
  input  logic [wbcc_pkg::StepW-1:0]       cstep,
  output wbcc_pkg::state_t                 nxt,
  output wbcc_pkg::result_t                res
);
  import wbcc_pkg::*;

  function automatic logic [MinW-1:0] wrap_up(input logic [MinW:0] v,
                                              input logic [MinW-1:0] lim);
    logic [MinW-1:0] r;
    r = (v > {1'b0, lim}) ? '0 : v[MinW-1:0];
    return r;
  endfunction

  function automatic logic [VolW-1:0] norm_vol(input logic [VolW-1:0] v);
    logic [VolW-1:0] r;
    r = (v < 3'd1 || v > 3'd5) ? VOL_RESET : v;
    return r;
  endfunction

  always_comb begin
    logic [MinW-1:0] sel;
    logic [MinW-1:0] v0;
    logic [MinW-1:0] v;
    logic            entered;
    logic [MinW-1:0] run_min;
    logic [MinW-1:0] run_min_next;
    logic [SecW-1:0] sec_next;
    logic            expired;
    logic            do_clear;
    logic [VolW-1:0] vol;
    logic [BeepW-1:0] beep;

    nxt      = st;
    beep     = BEEP_NONE;
    do_clear = 1'b0;

    if (st.mode == MODE_SET_WORK) begin
      sel = st.work_min;
    end else if (st.mode == MODE_SET_BREAK) begin
      sel = st.break_min;
    end else begin
      sel = st.timer_min;
    end
    v0      = wrap_up({1'b0, sel}, limit);
    v       = v0;
    entered = 1'b0;
    if (is_key) begin
      if (key == KEY_UP_CRS) begin
        v = wrap_up({1'b0, v0} + {3'b000, cstep}, limit);
      end else if (key == KEY_DN_CRS) begin
        v = (v0 < {2'b00, cstep}) ? '0 : v0 - {2'b00, cstep};
      end else if (key == KEY_UP_FINE) begin
        v = wrap_up({1'b0, v0} + 7'd1, limit);
      end else if (key == KEY_DN_FINE) begin
        v = (v0 == '0) ? '0 : v0 - 6'd1;
      end else if (key == KEY_CONFIRM) begin
        v       = (v0 == '0) ? '0 : v0 - 6'd1;
        entered = 1'b1;
      end
    end

    if (st.mode == MODE_WORK_RUN) begin
      run_min = st.work_min;
    end else if (st.mode == MODE_BREAK_RUN) begin
      run_min = st.break_min;
    end else begin
      run_min = st.timer_min;
    end
    expired      = 1'b0;
    run_min_next = run_min;
    sec_next     = st.seconds;
    if (st.seconds != '0) begin
      sec_next = st.seconds - 6'd1;
    end else if (run_min != '0) begin
      sec_next     = SEC_RELOAD;
      run_min_next = run_min - 6'd1;
    end else begin
      expired = 1'b1;
    end

    vol = norm_vol(st.volume);

    unique case (st.mode)
      MODE_SELECT: begin
        nxt.volume = vol;
        if (is_key) begin
          if (key == KEY_POMODORO) begin
            nxt.mode = MODE_SET_WORK;
            beep     = BEEP_ONE;
          end else if (key == KEY_TIMER) begin
            nxt.mode = MODE_SET_TIMER;
            beep     = BEEP_ONE;
          end else if (key == KEY_UP_FINE) begin
            nxt.volume = norm_vol(vol + 3'd1);
            beep       = BEEP_ONE;
          end else if (key == KEY_DN_FINE) begin
            nxt.volume = norm_vol(vol - 3'd1);
            beep       = BEEP_ONE;
          end
        end
      end
      MODE_SET_WORK: begin
        nxt.work_min = v;
        if (is_key && key == KEY_ABORT) begin
          nxt.mode = MODE_SELECT;
        end else if (entered) begin
          nxt.saved_work = v;
          nxt.mode       = MODE_SET_BREAK;
        end
      end
      MODE_SET_BREAK: begin
        nxt.break_min = v;
        if (is_key && key == KEY_ABORT) begin
          nxt.mode = MODE_SELECT;
        end else if (entered) begin
          nxt.saved_break = v;
          nxt.mode        = MODE_WORK_RUN;
        end
      end
      MODE_SET_TIMER: begin
        nxt.timer_min = v;
        if (is_key && key == KEY_ABORT) begin
          nxt.mode = MODE_SELECT;
        end else if (entered) begin
          nxt.mode = MODE_TIMER_RUN;
        end
      end
      MODE_TIMER_RUN: begin
        if (is_key) begin
          do_clear = (key == KEY_ABORT);
        end else begin
          nxt.timer_min = run_min_next;
          nxt.seconds   = sec_next;
          if (expired) begin
            nxt.seconds = '0;
            nxt.mode    = MODE_TIMER_DONE;
          end
        end
      end
      MODE_WORK_RUN: begin
        if (is_key) begin
          do_clear = (key == KEY_ABORT);
        end else begin
          nxt.work_min = run_min_next;
          nxt.seconds  = sec_next;
          if (expired) begin
            nxt.seconds = SEC_RELOAD;
            nxt.mode    = MODE_BREAK_RUN;
            beep        = BEEP_TWO;
          end
        end
      end
      MODE_BREAK_RUN: begin
        if (is_key) begin
          do_clear = (key == KEY_ABORT);
        end else begin
          nxt.break_min = run_min_next;
          nxt.seconds   = sec_next;
          if (expired) begin
            nxt.seconds = SEC_RELOAD;
            nxt.mode    = MODE_SESSION_DONE;
          end
        end
      end
      MODE_SESSION_DONE: begin
        beep = BEEP_FOUR;
        if (is_key) begin
          if (key == KEY_ABORT) begin
            do_clear = 1'b1;
          end else if (key == KEY_CONTINUE) begin
            nxt.work_min  = st.saved_work;
            nxt.break_min = st.saved_break;
            nxt.mode      = MODE_WORK_RUN;
          end
        end
      end
      MODE_TIMER_DONE: begin
        beep     = BEEP_FOUR;
        do_clear = is_key && (key == KEY_ABORT);
      end
      default: begin
      end
    endcase

    if (do_clear) begin
      nxt.mode      = MODE_SELECT;
      nxt.timer_min = '0;
      nxt.work_min  = '0;
      nxt.break_min = '0;
      nxt.seconds   = SEC_RELOAD;
    end

    res.mode = nxt.mode;
    unique case (nxt.mode)
      MODE_SET_WORK, MODE_WORK_RUN:                    res.minutes = nxt.work_min;
      MODE_SET_BREAK, MODE_BREAK_RUN:                  res.minutes = nxt.break_min;
      MODE_SET_TIMER, MODE_TIMER_RUN, MODE_TIMER_DONE: res.minutes = nxt.timer_min;
      default:                                         res.minutes = '0;
    endcase
    res.seconds = (nxt.mode == MODE_TIMER_DONE) ? '0 : nxt.seconds;
    res.volume  = nxt.volume;
    unique case (nxt.volume)
      3'd2:    res.gain = 8'd50;
      3'd3:    res.gain = 8'd100;
      3'd4:    res.gain = 8'd150;
      3'd5:    res.gain = 8'd250;
      default: res.gain = 8'd0;
    endcase
    res.beep = beep;
  end

endmodule

// ----- rtl/work_break_countdown_controller.sv -----
// ----------------------------------------------------------------------------
// Work/break countdown controller
// Pomodoro and plain timer control: event register, next-state logic and
// result register.
// ----------------------------------------------------------------------------
// The block takes one event transaction (a one-second tick or a key press)
// per clock cycle when the receiver does not stall it and returns exactly
// one result transaction for each, in order. An event is captured in the
// input register, the whole next-state and result computation is done in
// one pass of logic, and the result is held in the output register; the
// sustained rate is one event per cycle, set by that single registered pass.
// The input side accepts a new event while a finished result still waits.
// Configuration writes are taken at any time and should be made while no
// event is in flight.
module work_break_countdown_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [wbcc_pkg::KeyW-1:0]         key_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        mode,
  output logic [wbcc_pkg::MinW-1:0]         minutes_shown,
  output logic [wbcc_pkg::SecW-1:0]         seconds_shown,
  output logic [wbcc_pkg::VolW-1:0]         volume_level,
  output logic [wbcc_pkg::GainW-1:0]        speaker_volume,
  output logic [wbcc_pkg::BeepW-1:0]        beep_pattern,
  input  logic                              cfg_write,
  input  logic [wbcc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [wbcc_pkg::CfgDataW-1:0]     cfg_data
);
  import wbcc_pkg::*;

  logic              s1_valid;
  logic              s1_func;
  logic [KeyW-1:0]   s1_key;
  logic              in_accept;
  logic              advance;
  logic [MinW-1:0]   setting_limit;
  logic [StepW-1:0]  coarse_step;
  state_t            st;
  state_t            st_next;
  result_t           res_next;
  result_t           res;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func <= func;
      s1_key  <= key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setting_limit <= LIMIT_RESET;
      coarse_step   <= STEP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SETTING_LIMIT) begin
        setting_limit <= cfg_data;
      end else if (cfg_index == CFG_COARSE_STEP) begin
        coarse_step <= cfg_data[StepW-1:0];
      end
    end
  end

  wbcc_step u_step (
    .st     (st),
    .is_key (s1_func),
    .key    (s1_key),
    .limit  (setting_limit),
    .cstep  (coarse_step),
    .nxt    (st_next),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= MODE_SELECT;
      st.timer_min   <= '0;
      st.work_min    <= '0;
      st.break_min   <= '0;
      st.saved_work  <= '0;
      st.saved_break <= '0;
      st.seconds     <= SEC_RELOAD;
      st.volume      <= VOL_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign mode           = res.mode;
  assign minutes_shown  = res.minutes;
  assign seconds_shown  = res.seconds;
  assign volume_level   = res.volume;
  assign speaker_volume = res.gain;
  assign beep_pattern   = res.beep;

  a_volume_range: assert property (@(posedge clk) disable iff (rst)
    st.volume >= 3'd1 && st.volume <= 3'd5)
    else $error("Volume level left its range.");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    st.seconds <= SEC_RELOAD)
    else $error("Seconds counter exceeded its reload value.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("Input accepted while the pending transaction could not move.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("Result appeared without a captured transaction.");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Work/break countdown controller testbench
// A short table of key and tick events walks through the select, set, run
// and abort paths. Random pomodoro and timer sessions follow that run out to
// the done modes, mixed with stray keys, broken sessions and noise. They run
// under several limit and step settings. Every readout is checked against
// the table or a model of the controller kept in this file, with random
// sender gaps and receiver stalls, including one long stall.
// ----------------------------------------------------------------------------
module testbench;
  import wbcc_pkg::*;

  localparam logic EV_TICK = 1'b0;
  localparam logic EV_KEY = 1'b1;
  localparam logic CHECKED = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic [KeyW-1:0] KEY_NO_MEANING = 4'd15;
  localparam int VOL_MAX = 5;
  localparam result_t IDLE_SELECT = '{MODE_SELECT, 6'd0, SEC_RELOAD, VOL_RESET, 8'd0, BEEP_NONE};

  typedef struct packed {
    logic is_key;
    logic [KeyW-1:0] key;
    logic typed;
    result_t want;
  } script_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic func = 1'b0;
  logic [KeyW-1:0] key_code = '0;
  logic out_stall = 1'b0;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  logic [3:0] mode;
  logic [MinW-1:0] minutes_shown;
  logic [SecW-1:0] seconds_shown;
  logic [VolW-1:0] volume_level;
  logic [GainW-1:0] speaker_volume;
  logic [BeepW-1:0] beep_pattern;

  work_break_countdown_controller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .key_code(key_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mode(mode),
    .minutes_shown(minutes_shown),
    .seconds_shown(seconds_shown),
    .volume_level(volume_level),
    .speaker_volume(speaker_volume),
    .beep_pattern(beep_pattern),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Controller model state.
  mode_t ctl_mode = MODE_SELECT;
  logic [6:0] ctl_timer = '0;
  logic [6:0] ctl_work = '0;
  logic [6:0] ctl_break = '0;
  logic [MinW-1:0] ctl_saved_work = '0;
  logic [MinW-1:0] ctl_saved_break = '0;
  logic [SecW-1:0] ctl_sec = SEC_RELOAD;
  logic [VolW-1:0] ctl_vol = VOL_RESET;
  logic [MinW-1:0] ctl_limit = LIMIT_RESET;
  logic [StepW-1:0] ctl_step = STEP_RESET;

  result_t expected_readouts[$];
  int events_sent = 0;
  int readouts_checked = 0;
  int mismatch_count = 0;
  int burst_left = 0;

  logic [MinW-1:0] limit_plan[3] = '{6'd60, 6'd63, 6'd1};
  logic [StepW-1:0] step_plan[3] = '{4'd5, 4'd15, 4'd7};

  script_row_t script[24] = '{
    '{EV_TICK, KEY_ABORT, CHECKED, IDLE_SELECT},
    '{EV_KEY, KEY_UP_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd2, 8'd50, BEEP_ONE}},
    '{EV_KEY, KEY_UP_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd3, 8'd100, BEEP_ONE}},
    '{EV_KEY, KEY_UP_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd4, 8'd150, BEEP_ONE}},
    '{EV_KEY, KEY_UP_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd5, 8'd250, BEEP_ONE}},
    '{EV_KEY, KEY_UP_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_ONE}},
    '{EV_KEY, KEY_DN_FINE, CHECKED, '{MODE_SELECT, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_ONE}},
    '{EV_KEY, KEY_NO_MEANING, CHECKED, IDLE_SELECT},
    '{EV_KEY, KEY_POMODORO, CHECKED, '{MODE_SET_WORK, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_ONE}},
    '{EV_KEY, KEY_DN_FINE, CHECKED, '{MODE_SET_WORK, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_NONE}},
    '{EV_KEY, KEY_DN_CRS, CHECKED, '{MODE_SET_WORK, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_NONE}},
    '{EV_KEY, KEY_UP_CRS, PREDICTED, '0},
    '{EV_KEY, KEY_UP_FINE, PREDICTED, '0},
    '{EV_TICK, KEY_CONFIRM, PREDICTED, '0},
    '{EV_KEY, KEY_CONFIRM, PREDICTED, '0},
    '{EV_KEY, KEY_UP_FINE, PREDICTED, '0},
    '{EV_KEY, KEY_CONFIRM, PREDICTED, '0},
    '{EV_TICK, KEY_ABORT, PREDICTED, '0},
    '{EV_KEY, KEY_CONTINUE, PREDICTED, '0},
    '{EV_KEY, KEY_ABORT, CHECKED, IDLE_SELECT},
    '{EV_KEY, KEY_TIMER, CHECKED, '{MODE_SET_TIMER, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_ONE}},
    '{EV_KEY, KEY_DN_FINE, CHECKED, '{MODE_SET_TIMER, 6'd0, 6'd59, 3'd1, 8'd0, BEEP_NONE}},
    '{EV_KEY, KEY_UP_CRS, PREDICTED, '0},
    '{EV_KEY, KEY_ABORT, PREDICTED, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int fit_setting(input int v);
    return (v < 0 || v > int'(ctl_limit)) ? 0 : v;
  endfunction

  function automatic logic [VolW-1:0] tidy_volume(input int v);
    return (v < 1 || v > VOL_MAX) ? VOL_RESET : v[VolW-1:0];
  endfunction

  function automatic void clear_countdowns();
    ctl_mode = MODE_SELECT;
    ctl_timer = '0;
    ctl_work = '0;
    ctl_break = '0;
    ctl_sec = SEC_RELOAD;
  endfunction

  function automatic result_t advance_controller(input logic is_key, input logic [KeyW-1:0] k);
    result_t r;
    mode_t was;
    int v;
    bit entered;
    bit expired;
    logic [BeepW-1:0] beep;
    beep = BEEP_NONE;
    entered = 1'b0;
    expired = 1'b0;
    was = ctl_mode;
    case (was)
      MODE_SELECT: begin
        ctl_vol = tidy_volume(ctl_vol);
        if (is_key) begin
          if (k == KEY_POMODORO) begin
            ctl_mode = MODE_SET_WORK;
            beep = BEEP_ONE;
          end else if (k == KEY_TIMER) begin
            ctl_mode = MODE_SET_TIMER;
            beep = BEEP_ONE;
          end else if (k == KEY_UP_FINE) begin
            ctl_vol = tidy_volume(int'(ctl_vol) + 1);
            beep = BEEP_ONE;
          end else if (k == KEY_DN_FINE) begin
            ctl_vol = tidy_volume(int'(ctl_vol) - 1);
            beep = BEEP_ONE;
          end
        end
      end
      MODE_SET_WORK, MODE_SET_BREAK, MODE_SET_TIMER: begin
        v = fit_setting(was == MODE_SET_WORK ? ctl_work :
                        was == MODE_SET_BREAK ? ctl_break : ctl_timer);
        if (is_key) begin
          case (k)
            KEY_ABORT: ctl_mode = MODE_SELECT;
            KEY_UP_CRS: v = fit_setting(v + int'(ctl_step));
            KEY_DN_CRS: v = fit_setting(v - int'(ctl_step));
            KEY_UP_FINE: v = fit_setting(v + 1);
            KEY_DN_FINE: v = fit_setting(v - 1);
            KEY_CONFIRM: begin
              if (v > 0) v = v - 1;
              entered = 1'b1;
            end
            default: ;
          endcase
        end
        case (was)
          MODE_SET_WORK: ctl_work = v[6:0];
          MODE_SET_BREAK: ctl_break = v[6:0];
          default: ctl_timer = v[6:0];
        endcase
        if (entered) begin
          case (was)
            MODE_SET_WORK: begin
              ctl_saved_work = v[MinW-1:0];
              ctl_mode = MODE_SET_BREAK;
            end
            MODE_SET_BREAK: begin
              ctl_saved_break = v[MinW-1:0];
              ctl_mode = MODE_WORK_RUN;
            end
            default: ctl_mode = MODE_TIMER_RUN;
          endcase
        end
      end
      MODE_TIMER_RUN, MODE_WORK_RUN, MODE_BREAK_RUN: begin
        if (is_key) begin
          if (k == KEY_ABORT) clear_countdowns();
        end else begin
          v = was == MODE_TIMER_RUN ? ctl_timer : was == MODE_WORK_RUN ? ctl_work : ctl_break;
          if (ctl_sec > 0) begin
            ctl_sec = ctl_sec - 1'b1;
          end else if (v > 0) begin
            ctl_sec = SEC_RELOAD;
            v = v - 1;
          end else begin
            expired = 1'b1;
          end
          case (was)
            MODE_TIMER_RUN: ctl_timer = v[6:0];
            MODE_WORK_RUN: ctl_work = v[6:0];
            default: ctl_break = v[6:0];
          endcase
          if (expired) begin
            case (was)
              MODE_TIMER_RUN: begin
                ctl_sec = '0;
                ctl_mode = MODE_TIMER_DONE;
              end
              MODE_WORK_RUN: begin
                ctl_sec = SEC_RELOAD;
                beep = BEEP_TWO;
                ctl_mode = MODE_BREAK_RUN;
              end
              default: begin
                ctl_sec = SEC_RELOAD;
                ctl_mode = MODE_SESSION_DONE;
              end
            endcase
          end
        end
      end
      MODE_SESSION_DONE: begin
        beep = BEEP_FOUR;
        if (is_key && k == KEY_ABORT) begin
          clear_countdowns();
        end else if (is_key && k == KEY_CONTINUE) begin
          ctl_work = {1'b0, ctl_saved_work};
          ctl_break = {1'b0, ctl_saved_break};
          ctl_mode = MODE_WORK_RUN;
        end
      end
      MODE_TIMER_DONE: begin
        beep = BEEP_FOUR;
        if (is_key && k == KEY_ABORT) clear_countdowns();
      end
      default: ;
    endcase

    r.mode = ctl_mode;
    case (ctl_mode)
      MODE_SET_WORK, MODE_WORK_RUN: r.minutes = ctl_work[MinW-1:0];
      MODE_SET_BREAK, MODE_BREAK_RUN: r.minutes = ctl_break[MinW-1:0];
      MODE_SET_TIMER, MODE_TIMER_RUN, MODE_TIMER_DONE: r.minutes = ctl_timer[MinW-1:0];
      default: r.minutes = '0;
    endcase
    r.seconds = (ctl_mode == MODE_TIMER_DONE) ? '0 : ctl_sec;
    r.volume = ctl_vol;
    case (ctl_vol)
      3'd2: r.gain = 8'd50;
      3'd3: r.gain = 8'd100;
      3'd4: r.gain = 8'd150;
      3'd5: r.gain = 8'd250;
      default: r.gain = 8'd0;
    endcase
    r.beep = beep;
    return r;
  endfunction

  function automatic int live_setting();
    case (ctl_mode)
      MODE_SET_WORK: return fit_setting(ctl_work);
      MODE_SET_BREAK: return fit_setting(ctl_break);
      MODE_SET_TIMER: return fit_setting(ctl_timer);
      default: return 0;
    endcase
  endfunction

  // The sender works in bursts; each transaction is held until it is taken.
  task automatic send_event(input logic is_key, input logic [KeyW-1:0] k,
                            input logic typed, input result_t want);
    int gap;
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= is_key;
    key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_controller(is_key, k);
    expected_readouts.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  task automatic send_key(input logic [KeyW-1:0] k);
    send_event(EV_KEY, k, PREDICTED, '0);
  endtask

  task automatic send_tick(input logic [KeyW-1:0] k);
    send_event(EV_TICK, k, PREDICTED, '0);
  endtask

  task automatic send_noise();
    send_event(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), PREDICTED, '0);
  endtask

  task automatic go_select();
    if (ctl_mode != MODE_SELECT) send_key(KEY_ABORT);
  endtask

  task automatic dial_setting();
    int n;
    int target;
    int guard;
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: send_key(KEY_UP_CRS);
        1: send_key(KEY_DN_CRS);
        2: send_key(KEY_UP_FINE);
        3: send_key(KEY_DN_FINE);
        4: send_tick(4'($urandom_range(0, 15)));
        default: send_key(4'($urandom_range(6, 15)));
      endcase
    end
    // Keep the countdown short so that sessions reach their end.
    target = $urandom_range(0, 1);
    guard = 0;
    while (live_setting() > target && guard < 80) begin
      if (live_setting() - target >= int'(ctl_step)) send_key(KEY_DN_CRS);
      else send_key(KEY_DN_FINE);
      guard++;
    end
    send_key(KEY_CONFIRM);
  endtask

  task automatic run_to_end();
    int guard;
    guard = 0;
    while ((ctl_mode == MODE_WORK_RUN || ctl_mode == MODE_BREAK_RUN ||
            ctl_mode == MODE_TIMER_RUN) && guard < 6000) begin
      if ($urandom_range(0, 39) == 0) send_key(4'($urandom_range(1, 15)));
      else send_tick(4'($urandom_range(0, 15)));
      guard++;
    end
  endtask

  task automatic linger_in_done();
    int n;
    logic [KeyW-1:0] k;
    n = $urandom_range(0, 3);
    repeat (n) begin
      k = 4'($urandom_range(1, 14));
      if (k >= KEY_CONTINUE) k = k + 1'b1;
      if ($urandom_range(0, 1) == 0) send_tick(4'($urandom_range(0, 15)));
      else send_key(k);
    end
  endtask

  task automatic run_random(input int stop_at);
    int pick;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        go_select();
        send_key(KEY_POMODORO);
        dial_setting();
        dial_setting();
        run_to_end();
        if (ctl_mode == MODE_SESSION_DONE) begin
          linger_in_done();
          if ($urandom_range(0, 2) == 0) begin
            send_key(KEY_CONTINUE);
            run_to_end();
            linger_in_done();
          end
          if ($urandom_range(0, 1) == 0) send_key(KEY_ABORT);
        end
      end else if (pick < 70) begin
        go_select();
        send_key(KEY_TIMER);
        dial_setting();
        run_to_end();
        if (ctl_mode == MODE_TIMER_DONE) begin
          linger_in_done();
          if ($urandom_range(0, 1) == 0) send_key(KEY_ABORT);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_noise();
      end else begin
        go_select();
        send_key($urandom_range(0, 1) == 0 ? KEY_POMODORO : KEY_TIMER);
        repeat ($urandom_range(1, 8)) send_noise();
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [MinW-1:0] limit, input logic [StepW-1:0] step);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SETTING_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= CFG_COARSE_STEP;
    cfg_data <= {{(CfgDataW-StepW){1'b0}}, step};
    @(posedge clk);
    cfg_write <= 1'b0;
    ctl_limit = limit;
    ctl_step = step;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_readout();
    result_t want;
    readouts_checked++;
    if (expected_readouts.size() == 0) begin
      $display("%0t: readout expected none, got mode %0d", $time, mode);
      mismatch_count++;
    end else begin
      want = expected_readouts.pop_front();
      check_field("mode", 8'(want.mode), 8'(mode));
      check_field("minutes_shown", 8'(want.minutes), 8'(minutes_shown));
      check_field("seconds_shown", 8'(want.seconds), 8'(seconds_shown));
      check_field("volume_level", 8'(want.volume), 8'(volume_level));
      check_field("speaker_volume", want.gain, speaker_volume);
      check_field("beep_pattern", 8'(want.beep), 8'(beep_pattern));
    end
  endtask

  // The receiver changes its stall rate every stretch and once holds off
  // long enough for the block to back up into its input.
  initial begin : readout_sink
    int stall_pct;
    int stretch_left;
    int hold_left;
    bit held;
    stall_pct = 0;
    stretch_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_readout();
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      stretch_left--;
      if (!held && readouts_checked >= 150) begin
        hold_left = 64;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_event(script[i].is_key, script[i].key, script[i].typed,
                                   script[i].want);
    for (int p = 0; p < 3; p++) begin
      if (p > 0) begin
        settle();
        apply_settings(limit_plan[p], step_plan[p]);
      end
      run_random(events_sent + 60);
    end
    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
